@@ sv/gbd_pkg.sv @@
// Package for the Gaussian bump displacement pipeline: fixed-point widths,
// register indexes, stage payload types and the constant root table.
// No dependencies.
package gbd_pkg;

  // Vertex and register formats
  localparam int COORD_W     = 32;
  localparam int FWHM_W      = 31;
  localparam int FRAC_BITS   = 16;
  localparam logic [FWHM_W-1:0] FWHM_RESET = FWHM_W'(1) << FRAC_BITS;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_X   = 3'd0,
    REG_CENTRE_Y   = 3'd1,
    REG_CENTRE_Z   = 3'd2,
    REG_WIDTH_FWHM = 3'd3,
    REG_AMPLITUDE  = 3'd4
  } cfg_reg_t;

  // Distance and exponent arithmetic
  localparam int DIFF_W      = COORD_W + 1;          // signed difference
  localparam int SQ_W        = 2 * COORD_W + 1;      // squared distance, unsigned
  localparam int SUM_W       = SQ_W + 1;             // sum of three squares
  localparam int DEN_W       = 2 * FWHM_W;           // fwhm squared
  localparam int REM_W       = DEN_W;                // remainder stays below fwhm^2
  localparam int EXP_FRAC    = 16;                   // fraction bits of the exponent
  localparam int T_LIMIT_INT = 32;                   // exponent cut-off, integer part
  localparam int N_W         = $clog2(T_LIMIT_INT);  // integer part of the exponent
  localparam int QUO_BITS    = N_W + EXP_FRAC;       // quotient bits below the cut-off
  localparam int SCALE_SHIFT = EXP_FRAC + 2;         // factor 4 and the Q.16 scale
  localparam int LOW_BITS    = QUO_BITS - SCALE_SHIFT;

  // Weight arithmetic, Q1.30 product and Q1.16 result
  localparam int Q_W         = 30;
  localparam int V_W         = Q_W + 1;
  localparam int WEIGHT_BITS = 16;
  localparam int W_W         = WEIGHT_BITS + 1;
  localparam int SHIFT_BASE  = Q_W - WEIGHT_BITS;
  localparam int SH_W        = $clog2(SHIFT_BASE + T_LIMIT_INT);
  localparam int ACC_W       = SHIFT_BASE + T_LIMIT_INT + 1;
  localparam int PROD_W      = COORD_W + W_W;        // amplitude times weight

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vtx_t;

  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [QUO_BITS-1:0] quo;
    logic [LOW_BITS-1:0] low;
    logic                sat;
  } div_t;

  typedef struct packed {
    logic [V_W-1:0]      v;
    logic [EXP_FRAC-1:0] frac;
    logic [N_W-1:0]      n;
    logic                sat;
  } wgt_t;

  // Integer square root, bit by bit
  function automatic logic [63:0] isqrt64(logic [63:0] a);
    logic [63:0] rest;
    logic [63:0] res;
    logic [63:0] b;
    rest = a;
    res  = '0;
    b    = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rest >= res + b) begin
        rest = rest - (res + b);
        res  = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Factors 2^-(2^-(j+1)) in Q0.30, each the root of the one before, from the root of 0.5
  function automatic logic [EXP_FRAC*Q_W-1:0] root_table();
    logic [63:0]              r;
    logic [EXP_FRAC*Q_W-1:0]  tbl;
    r   = 64'd1 << (Q_W - 1);
    tbl = '0;
    for (int j = 0; j < EXP_FRAC; j++) begin
      r = isqrt64(r << Q_W);
      tbl[j*Q_W +: Q_W] = r[Q_W-1:0];
    end
    return tbl;
  endfunction

  localparam logic [EXP_FRAC*Q_W-1:0] ROOT_TBL = root_table();

endpackage

@@ sv/gaussian_bump_displace.sv @@
// Gaussian bump displacement: a vertex pipeline that adds amplitude * w to x.
// Depends on gbd_pkg (widths, register indexes, stage types, root table).
//
// Takes one vertex per clock while busy is low and returns each result in order,
// one result beat per vertex. The pipeline is made of the bit-per-stage
// exponent divider (22 stages: range check plus 21 quotient bits) and the
// 16-stage weight multiplier chain, plus diff, square, sum, weight shift,
// amplitude multiply and saturation stages. busy is high in reset and in the
// first cycle after it; otherwise a new vertex is taken every cycle.
// Result beats carry no back-pressure and must be taken when out_valid is high.
// Write configuration only with the pipeline empty, i.e. after the last start beat has
// come out with out_valid and before the next one.
module gaussian_bump_displace
  import gbd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_vertex_x,
  input  logic signed [COORD_W-1:0] in_vertex_y,
  input  logic signed [COORD_W-1:0] in_vertex_z,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_data,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_moved_x,
  output logic signed [COORD_W-1:0] out_same_y,
  output logic signed [COORD_W-1:0] out_same_z,
  output logic                      out_clipped
);

  // Stage map
  localparam int ST_DIFF    = 0;
  localparam int ST_SQ      = 1;
  localparam int ST_SUM     = 2;
  localparam int ST_DIV     = 3;
  localparam int DIV_STAGES = QUO_BITS + 1;
  localparam int ST_WGT     = ST_DIV + DIV_STAGES;
  localparam int WGT_STAGES = EXP_FRAC;
  localparam int ST_SHIFT   = ST_WGT + WGT_STAGES;
  localparam int ST_MUL     = ST_SHIFT + 1;
  localparam int ST_OUT     = ST_MUL + 1;
  localparam int LAT        = ST_OUT + 1;

  localparam logic [V_W-1:0]   V_ONE   = V_W'(1) << Q_W;
  localparam logic [2*V_W-2:0] V_HALF  = (2*V_W-1)'(1) << (Q_W - 1);
  localparam logic signed [PROD_W-2:0] P_HALF = (PROD_W-1)'(1) << (WEIGHT_BITS - 1);
  localparam logic signed [COORD_W-1:0] X_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] X_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Configuration and control registers
  logic signed [COORD_W-1:0] cx_r, cy_r, cz_r, amp_r;
  logic [FWHM_W-1:0]         fwhm_r;
  logic                      busy_r;
  logic [LAT-1:0]            vld_r;
  logic                      accept;

  // Payload registers
  logic [DEN_W-1:0]          den_r, den_nxt;
  logic [FWHM_W-1:0]         f_eff;
  vtx_t                      pass_r [LAT];
  logic signed [DIFF_W-1:0]  dx_r, dy_r, dz_r, dx_nxt, dy_nxt, dz_nxt;
  logic signed [2*DIFF_W-1:0] sqx_full, sqy_full, sqz_full;
  logic [SQ_W-1:0]           sqx_r, sqy_r, sqz_r;
  logic [SUM_W-1:0]          sum_r, sum_nxt;
  div_t                      div_r [DIV_STAGES];
  div_t                      div_nxt [DIV_STAGES];
  wgt_t                      wgt_in [WGT_STAGES];
  wgt_t                      wgt_r [WGT_STAGES];
  wgt_t                      wgt_nxt [WGT_STAGES];
  logic [W_W-1:0]            w_r, w_nxt;
  logic signed [PROD_W:0]    p_full;
  logic signed [PROD_W-2:0]  p_r, p_nxt;
  logic signed [COORD_W-1:0] moved_r, moved_nxt;
  logic                      clip_r, clip_nxt;

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  // Control: busy after reset, valid chain, configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
      cx_r   <= '0;
      cy_r   <= '0;
      cz_r   <= '0;
      fwhm_r <= FWHM_RESET;
      amp_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[LAT-2:0], accept};
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CENTRE_X:   cx_r   <= cfg_data;
          REG_CENTRE_Y:   cy_r   <= cfg_data;
          REG_CENTRE_Z:   cz_r   <= cfg_data;
          REG_WIDTH_FWHM: fwhm_r <= cfg_data[FWHM_W-1:0];
          REG_AMPLITUDE:  amp_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Denominator fwhm^2, zero width taken as one LSB
  always_comb begin
    f_eff   = (fwhm_r == '0) ? FWHM_W'(1) : fwhm_r;
    den_nxt = DEN_W'(f_eff) * DEN_W'(f_eff);
  end

  // Front: differences, squares, sum
  always_comb begin
    dx_nxt   = $signed({in_vertex_x[COORD_W-1], in_vertex_x} - {cx_r[COORD_W-1], cx_r});
    dy_nxt   = $signed({in_vertex_y[COORD_W-1], in_vertex_y} - {cy_r[COORD_W-1], cy_r});
    dz_nxt   = $signed({in_vertex_z[COORD_W-1], in_vertex_z} - {cz_r[COORD_W-1], cz_r});
    sqx_full = dx_r * dx_r;
    sqy_full = dy_r * dy_r;
    sqz_full = dz_r * dz_r;
    sum_nxt  = SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);
  end

  // Divider: range check, then one quotient bit per stage
  always_comb begin
    logic [SUM_W-LOW_BITS-1:0] rem0;
    logic [REM_W:0]            shl;
    logic                      ge;
    rem0           = sum_r[SUM_W-1:LOW_BITS];
    div_nxt[0].sat = (rem0 >= {1'b0, den_r});
    div_nxt[0].rem = div_nxt[0].sat ? '0 : rem0[REM_W-1:0];
    div_nxt[0].quo = '0;
    div_nxt[0].low = sum_r[LOW_BITS-1:0];
    for (int i = 1; i < DIV_STAGES; i++) begin
      shl            = {div_r[i-1].rem, div_r[i-1].low[LOW_BITS-1]};
      ge             = (shl >= {1'b0, den_r});
      div_nxt[i].rem = ge ? REM_W'(shl - {1'b0, den_r}) : shl[REM_W-1:0];
      div_nxt[i].quo = {div_r[i-1].quo[QUO_BITS-2:0], ge};
      div_nxt[i].low = div_r[i-1].low << 1;
      div_nxt[i].sat = div_r[i-1].sat;
    end
  end

  // Weight chain: multiply in one root factor per set fraction bit
  always_comb begin
    logic [2*V_W-2:0] prod;
    logic [2*V_W-2:0] rnd;
    wgt_in[0].v    = V_ONE;
    wgt_in[0].frac = div_r[DIV_STAGES-1].quo[EXP_FRAC-1:0];
    wgt_in[0].n    = div_r[DIV_STAGES-1].quo[QUO_BITS-1:EXP_FRAC];
    wgt_in[0].sat  = div_r[DIV_STAGES-1].sat;
    for (int j = 1; j < WGT_STAGES; j++) begin
      wgt_in[j] = wgt_r[j-1];
    end
    for (int j = 0; j < WGT_STAGES; j++) begin
      prod       = wgt_in[j].v * ROOT_TBL[j*Q_W +: Q_W];
      rnd        = (prod + V_HALF) >> Q_W;
      wgt_nxt[j] = wgt_in[j];
      if (wgt_in[j].frac[EXP_FRAC-1-j]) begin
        wgt_nxt[j].v = rnd[V_W-1:0];
      end
    end
  end

  // Back end: scale by 2^-n with rounding (zero past the cut-off), multiply, round and saturate
  always_comb begin
    logic [SH_W-1:0]         shamt;
    logic [ACC_W-1:0]        acc;
    logic signed [PROD_W-2:0] prnd;
    logic signed [COORD_W+1:0] res;
    shamt = SH_W'(SHIFT_BASE) + SH_W'(wgt_r[WGT_STAGES-1].n);
    acc   = (ACC_W'(wgt_r[WGT_STAGES-1].v) + (ACC_W'(1) << (shamt - SH_W'(1)))) >> shamt;
    w_nxt = wgt_r[WGT_STAGES-1].sat ? '0 : acc[W_W-1:0];

    p_full = amp_r * $signed({1'b0, w_r});
    p_nxt  = p_full[PROD_W-2:0];

    prnd = p_r + P_HALF;
    res  = $signed({{2{pass_r[ST_MUL].x[COORD_W-1]}}, pass_r[ST_MUL].x})
         + $signed({prnd[PROD_W-2], prnd[PROD_W-2:WEIGHT_BITS]});
    clip_nxt  = (res[COORD_W+1:COORD_W-1] != {3{res[COORD_W-1]}});
    moved_nxt = clip_nxt ? (res[COORD_W+1] ? X_MIN : X_MAX) : res[COORD_W-1:0];
  end

  // Datapath registers advance every cycle
  always_ff @(posedge clk) begin
    den_r     <= den_nxt;
    pass_r[0] <= '{x: in_vertex_x, y: in_vertex_y, z: in_vertex_z};
    for (int s = 1; s < LAT; s++) begin
      pass_r[s] <= pass_r[s-1];
    end
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    dz_r  <= dz_nxt;
    sqx_r <= sqx_full[SQ_W-1:0];
    sqy_r <= sqy_full[SQ_W-1:0];
    sqz_r <= sqz_full[SQ_W-1:0];
    sum_r <= sum_nxt;
    for (int i = 0; i < DIV_STAGES; i++) begin
      div_r[i] <= div_nxt[i];
    end
    for (int j = 0; j < WGT_STAGES; j++) begin
      wgt_r[j] <= wgt_nxt[j];
    end
    w_r     <= w_nxt;
    p_r     <= p_nxt;
    moved_r <= moved_nxt;
    clip_r  <= clip_nxt;
  end

  assign out_valid   = vld_r[ST_OUT];
  assign out_moved_x = moved_r;
  assign out_clipped = clip_r;
  assign out_same_y  = pass_r[ST_OUT].y;
  assign out_same_z  = pass_r[ST_OUT].z;

`ifndef NO_ASSERTIONS
  // Clipped results sit on a range limit
  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> (out_moved_x == X_MAX || out_moved_x == X_MIN))
    else $error("clipped result not at a range limit");

  // Weight never exceeds 1.0
  a_weight_max: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_SHIFT] |-> (w_r <= (W_W'(1) << WEIGHT_BITS)))
    else $error("weight above one");

  // Exponent past the cut-off gives zero weight
  a_weight_cut: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_SHIFT] && $past(wgt_r[WGT_STAGES-1].sat) |-> (w_r == '0))
    else $error("nonzero weight beyond exponent cut-off");

  // Divider remainder stays below the denominator
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_WGT-1] |-> (div_r[DIV_STAGES-1].rem < den_r))
    else $error("divider remainder out of range");
`endif

endmodule
